@@ hdl/stl_pkg.sv @@
// stl_pkg: token codes, result beat type and lexeme tables for the source text tokenizer.
// No dependencies; used by every module of the block.
package stl_pkg;

	localparam logic [5:0] TK_IDENT = 6'd0;
	localparam logic [5:0] TK_INT   = 6'd1;
	localparam logic [5:0] TK_STR   = 6'd2;
	localparam logic [5:0] TK_KW0   = 6'd3;
	localparam logic [5:0] TK_OP0   = 6'd17;
	localparam logic [5:0] TK_EOF   = 6'd39;

	localparam int NUM_KW = 14;

	// index of the first compare operator in the operator list
	localparam logic [4:0] OP_CMP0 = 5'd14;

	// pending compare operator codes
	localparam logic [2:0] PEND_NONE = 3'd0;
	localparam logic [2:0] PEND_GT   = 3'd1;
	localparam logic [2:0] PEND_LT   = 3'd2;
	localparam logic [2:0] PEND_EQ   = 3'd3;
	localparam logic [2:0] PEND_NOT  = 3'd4;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_BANG  = 8'h21;

	// "eofl", first character in the lowest byte
	localparam logic [63:0] EOF_TEXT = 64'h0000_0000_6c66_6f65;

	// keywords, right-justified, and their lengths
	localparam logic [47:0] KW_STR [NUM_KW] = '{
		48'("for"), 48'("or"), 48'("if"), 48'("else"), 48'("return"), 48'("print"),
		48'("int"), 48'("str"), 48'("true"), 48'("false"), 48'("nil"), 48'("and"),
		48'("while"), 48'("def")};
	localparam int KW_LEN [NUM_KW] = '{3, 2, 2, 4, 6, 5, 3, 3, 4, 5, 3, 3, 5, 3};

	typedef struct packed {
		logic [5:0]  token_code;
		logic [15:0] line_number;
		logic [10:0] column;
		logic [15:0] text_length;
		logic [63:0] text_first_eight;
		logic [63:0] text_next_eight;
		logic        truncated;
		logic        last;
	} tok_t;

	// up to two result beats produced by one input beat
	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} push_t;

	// byte j (0-based) of keyword k
	function automatic logic [7:0] kw_char(input int k, input int j);
		kw_char = KW_STR[k][8*(KW_LEN[k]-1-j) +: 8];
	endfunction

	// single-character operator index, or 5'h1f when c is none of them
	function automatic logic [4:0] single_op(input logic [7:0] c);
		case (c)
			8'h2c:   single_op = 5'd0;
			8'h3b:   single_op = 5'd1;
			8'h28:   single_op = 5'd2;
			8'h29:   single_op = 5'd3;
			8'h7b:   single_op = 5'd4;
			8'h7d:   single_op = 5'd5;
			8'h2b:   single_op = 5'd6;
			8'h2d:   single_op = 5'd7;
			8'h2a:   single_op = 5'd8;
			8'h2f:   single_op = 5'd9;
			8'h7c:   single_op = 5'd10;
			8'h26:   single_op = 5'd11;
			8'h5e:   single_op = 5'd12;
			8'h3a:   single_op = 5'd13;
			default: single_op = 5'h1f;
		endcase
	endfunction

	// first character of an operator
	function automatic logic [7:0] op_char(input logic [4:0] idx);
		case (idx)
			5'd0:  op_char = 8'h2c;
			5'd1:  op_char = 8'h3b;
			5'd2:  op_char = 8'h28;
			5'd3:  op_char = 8'h29;
			5'd4:  op_char = 8'h7b;
			5'd5:  op_char = 8'h7d;
			5'd6:  op_char = 8'h2b;
			5'd7:  op_char = 8'h2d;
			5'd8:  op_char = 8'h2a;
			5'd9:  op_char = 8'h2f;
			5'd10: op_char = 8'h7c;
			5'd11: op_char = 8'h26;
			5'd12: op_char = 8'h5e;
			5'd13: op_char = 8'h3a;
			5'd14, 5'd15: op_char = CH_GT;
			5'd16, 5'd17: op_char = CH_LT;
			5'd18, 5'd19: op_char = CH_EQ;
			5'd20, 5'd21: op_char = CH_BANG;
			default: op_char = 8'h00;
		endcase
	endfunction

	// operator result beat; odd compare indexes are the two-character forms
	function automatic tok_t op_tok(input logic [4:0] idx, input logic [10:0] col,
			input logic [15:0] line);
		logic two;
		tok_t t;
		two = (idx >= OP_CMP0) && idx[0];
		t = '0;
		t.token_code = TK_OP0 + {1'b0, idx};
		t.line_number = line;
		t.column = col;
		t.text_length = two ? 16'd2 : 16'd1;
		t.text_first_eight = {48'd0, (two ? CH_EQ : 8'h00), op_char(idx)};
		op_tok = t;
	endfunction

endpackage

@@ hdl/stl_in_if.sv @@
// stl_in_if: input channel of the tokenizer, one source byte or end of input per beat.
// Depends on nothing.
interface stl_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source (output valid, kind, char_code, input ready);
	modport sink (input valid, kind, char_code, output ready);
endinterface

@@ hdl/stl_out_if.sv @@
// stl_out_if: result channel of the tokenizer, one token per beat.
// Depends on nothing.
interface stl_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_code;
	logic [15:0] line_number;
	logic [10:0] column;
	logic [15:0] text_length;
	logic [63:0] text_first_eight;
	logic [63:0] text_next_eight;
	logic        truncated;
	logic        last;

	modport source (output valid, token_code, line_number, column, text_length,
		text_first_eight, text_next_eight, truncated, last, input ready);
	modport sink (input valid, token_code, line_number, column, text_length,
		text_first_eight, text_next_eight, truncated, last, output ready);
endinterface

@@ hdl/stl_step.sv @@
// stl_step: next-state and token logic for one input beat of the tokenizer.
// Depends on stl_pkg; purely combinational, state lives in the top level.
module stl_step import stl_pkg::*; #(
	parameter int MAX_TEXT = 16,
	parameter int MAX_LINE = 1024,
	localparam int CW = $clog2(MAX_LINE + 1),
	localparam int IW = $clog2(MAX_TEXT + 1)
) (
	input  logic          kind,
	input  logic [7:0]    char_code,
	input  logic [7:0]    text [MAX_TEXT+1],
	input  logic [16:0]   wlen,
	input  logic          digits,
	input  logic          fquote,
	input  logic          lquote,
	input  logic [15:0]   line,
	input  logic [CW-1:0] colidx,
	input  logic          cmt,
	input  logic [2:0]    pend,
	input  logic [CW-1:0] ppos,
	input  logic          lhb,
	output logic [16:0]   wlen_d,
	output logic          digits_d,
	output logic          fquote_d,
	output logic          lquote_d,
	output logic [15:0]   line_d,
	output logic [CW-1:0] colidx_d,
	output logic          cmt_d,
	output logic [2:0]    pend_d,
	output logic [CW-1:0] ppos_d,
	output logic          lhb_d,
	output logic          text_we,
	output logic [IW-1:0] text_idx,
	output push_t         push
);

	logic [10:0] col_cur, col_pend;
	logic [15:0] line_inc;
	logic [CW-1:0] colidx_adv;
	logic [4:0] sop, pidx;
	logic is_kw, is_str;
	logic [5:0] kw_code;
	logic [16:0] slen;
	logic [IW-1:0] nbytes;
	logic [7:0] ob [16];
	tok_t word_tok, tok_a, tok_b;
	logic va, vb;

	// 1-based column, saturating at the line limit
	function automatic logic [10:0] col_of(input logic [CW-1:0] idx);
		logic [CW:0] c;
		c = {1'b0, idx} + (CW+1)'(1);
		if (c > (CW+1)'(MAX_LINE))
			c = (CW+1)'(MAX_LINE);
		col_of = 11'(c);
	endfunction

	assign col_cur  = col_of(colidx);
	assign col_pend = col_of(ppos);
	assign line_inc = (line == 16'hffff) ? line : line + 16'd1;
	assign colidx_adv = (colidx == CW'(MAX_LINE)) ? colidx : colidx + CW'(1);
	assign sop  = single_op(char_code);
	assign pidx = OP_CMP0 + {pend[1:0] - 2'd1, 1'b0};

	// keyword match over the stored word
	always_comb begin
		logic m;
		is_kw = 1'b0;
		kw_code = TK_IDENT;
		for (int k = 0; k < NUM_KW; k++) begin
			m = (wlen == 17'(KW_LEN[k]));
			for (int j = 0; j < 6; j++)
				if (j < KW_LEN[k] && text[j] != kw_char(k, j))
					m = 1'b0;
			if (m && !is_kw) begin
				is_kw = 1'b1;
				kw_code = TK_KW0 + 6'(k);
			end
		end
	end

	// word token; column is filled in by the lexer logic below
	assign is_str = !is_kw && !digits && fquote && lquote;
	assign slen = is_str ? ((wlen >= 17'd2) ? wlen - 17'd2 : 17'd0) : wlen;
	assign nbytes = (slen > 17'(MAX_TEXT)) ? IW'(MAX_TEXT) : slen[IW-1:0];

	always_comb begin
		int src;
		for (int i = 0; i < 16; i++) begin
			src = (i < MAX_TEXT) ? (is_str ? i + 1 : i) : 0;
			ob[i] = (i < MAX_TEXT && IW'(i) < nbytes) ? text[src] : 8'h00;
		end
	end

	always_comb begin
		word_tok = '0;
		word_tok.token_code = is_kw ? kw_code : digits ? TK_INT : is_str ? TK_STR : TK_IDENT;
		word_tok.line_number = line;
		word_tok.text_length = (slen > 17'hffff) ? 16'hffff : slen[15:0];
		word_tok.truncated = slen > 17'(MAX_TEXT);
		for (int i = 0; i < 8; i++) begin
			word_tok.text_first_eight[8*i +: 8] = ob[i];
			word_tok.text_next_eight[8*i +: 8]  = ob[i+8];
		end
	end

	// one byte of the lexer
	always_comb begin
		wlen_d = wlen; digits_d = digits; fquote_d = fquote; lquote_d = lquote;
		line_d = line; colidx_d = colidx; cmt_d = cmt; pend_d = pend;
		ppos_d = ppos; lhb_d = lhb;
		text_we = 1'b0;
		text_idx = wlen[IW-1:0];
		va = 1'b0; vb = 1'b0;
		tok_a = word_tok; tok_b = '0;
		if (kind) begin
			// end of input: flush the open line, emit end-of-file, back to reset
			if (lhb) begin
				if (pend != PEND_NONE) begin
					va = 1'b1; tok_a = op_tok(pidx, col_pend, line);
				end else if (wlen != 17'd0) begin
					va = 1'b1; tok_a.column = 11'd1;
				end
			end
			vb = 1'b1;
			tok_b.token_code = TK_EOF;
			tok_b.line_number = lhb ? line_inc : line;
			tok_b.text_length = 16'd4;
			tok_b.text_first_eight = EOF_TEXT;
			wlen_d = '0; digits_d = 1'b1; fquote_d = 1'b0; lquote_d = 1'b0;
			line_d = 16'd1; colidx_d = '0; cmt_d = 1'b0; pend_d = PEND_NONE;
			ppos_d = '0; lhb_d = 1'b0;
		end else if (char_code == CH_NL) begin
			if (pend != PEND_NONE) begin
				va = 1'b1; tok_a = op_tok(pidx, col_pend, line);
			end else if (wlen != 17'd0) begin
				va = 1'b1; tok_a.column = 11'd1;
			end
			wlen_d = '0; digits_d = 1'b1; fquote_d = 1'b0; lquote_d = 1'b0;
			pend_d = PEND_NONE;
			line_d = line_inc; colidx_d = '0; cmt_d = 1'b0; lhb_d = 1'b0;
		end else begin
			lhb_d = 1'b1;
			colidx_d = colidx_adv;
			if (!cmt) begin
				pend_d = PEND_NONE;
				if (pend != PEND_NONE && char_code == CH_EQ) begin
					va = 1'b1; tok_a = op_tok(pidx + 5'd1, col_cur, line);
				end else begin
					if (pend != PEND_NONE) begin
						va = 1'b1; tok_a = op_tok(pidx, col_pend, line);
					end
					if (char_code == CH_HASH || char_code == CH_GT || char_code == CH_LT
							|| char_code == CH_EQ || char_code == CH_BANG
							|| char_code == 8'd9 || char_code == 8'd11 || char_code == 8'd12
							|| char_code == 8'd13 || char_code == 8'd32 || sop != 5'h1f) begin
						// delimiter: close the word
						if (wlen != 17'd0) begin
							va = 1'b1;
							tok_a.column = (char_code == CH_HASH) ? 11'd1 : col_cur;
						end
						wlen_d = '0; digits_d = 1'b1; fquote_d = 1'b0; lquote_d = 1'b0;
						if (char_code == CH_HASH)
							cmt_d = 1'b1;
						if (char_code == CH_GT || char_code == CH_LT
								|| char_code == CH_EQ || char_code == CH_BANG) begin
							pend_d = (char_code == CH_GT) ? PEND_GT :
								(char_code == CH_LT) ? PEND_LT :
								(char_code == CH_EQ) ? PEND_EQ : PEND_NOT;
							ppos_d = colidx;
						end
						if (sop != 5'h1f) begin
							vb = 1'b1; tok_b = op_tok(sop, col_cur, line);
						end
					end else begin
						// word byte
						text_we = (wlen < 17'(MAX_TEXT + 1));
						if (wlen == 17'd0)
							fquote_d = (char_code == CH_QUOTE);
						lquote_d = (char_code == CH_QUOTE);
						if (char_code < 8'h30 || char_code > 8'h39)
							digits_d = 1'b0;
						if (wlen < 17'd65537)
							wlen_d = wlen + 17'd1;
					end
				end
			end
		end
	end

	// pack the beats in order and mark the final one
	always_comb begin
		push = '0;
		push.n = {1'b0, va} + {1'b0, vb};
		push.t0 = va ? tok_a : tok_b;
		push.t1 = tok_b;
		push.t0.last = (push.n == 2'd1);
		push.t1.last = 1'b1;
	end

endmodule

@@ hdl/stl_outq.sv @@
// stl_outq: two-entry result buffer between the lexer and the token channel.
// Depends on stl_pkg.
module stl_outq import stl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       pop,
	output tok_t       head,
	output logic [1:0] count
);

	tok_t slot_q [2];
	tok_t s0, s1;
	logic [1:0] cnt_q, base, cnt_d;

	// drop the head on a pop, then append new beats behind what is left
	always_comb begin
		s0 = slot_q[0];
		s1 = slot_q[1];
		base = cnt_q;
		if (pop) begin
			s0 = slot_q[1];
			base = cnt_q - 2'd1;
		end
		if (push.n != 2'd0) begin
			if (base == 2'd0) begin
				s0 = push.t0;
				s1 = push.t1;
			end else begin
				s1 = push.t0;
			end
		end
		cnt_d = base + push.n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q[0] <= s0;
		slot_q[1] <= s1;
	end

	assign head = slot_q[0];
	assign count = cnt_q;

endmodule

@@ hdl/source_text_tokenizer_core.sv @@
// A byte's first token appears on the result channel the cycle after the byte is accepted.
// Throughput: one byte per cycle while the result channel is ready and no byte gives two
// tokens; such a byte fills the two-entry buffer and stalls input until the single result
// port drains an entry. Reset (arst_n low, asynchronous): line 1, column 0, no word, no
// comment, nothing pending, buffer empty. End of input returns the lexer to the same state.
// No clearing pass. Depends on stl_pkg, stl_in_if, stl_out_if, stl_step, stl_outq.
module source_text_tokenizer_core import stl_pkg::*; #(
	parameter int MAX_TEXT = 16,
	parameter int MAX_LINE = 1024
) (
	input logic        clk,
	input logic        arst_n,
	stl_in_if.sink     source_bytes,
	stl_out_if.source  tokens
);

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam int IW = $clog2(MAX_TEXT + 1);

	logic [7:0] word_text_q [MAX_TEXT+1];
	logic [16:0] wlen_q, wlen_d;
	logic digits_q, digits_d, fquote_q, fquote_d, lquote_q, lquote_d;
	logic [15:0] line_q, line_d;
	logic [CW-1:0] colidx_q, colidx_d, ppos_q, ppos_d;
	logic cmt_q, cmt_d, lhb_q, lhb_d;
	logic [2:0] pend_q, pend_d;
	logic text_we;
	logic [IW-1:0] text_idx;
	push_t step_push, push;
	tok_t head;
	logic [1:0] count;
	logic in_fire, out_fire;

	assign in_fire  = source_bytes.valid && source_bytes.ready;
	assign out_fire = tokens.valid && tokens.ready;
	assign source_bytes.ready = (count == 2'd0) || (count == 2'd1 && tokens.ready);

	stl_step #(.MAX_TEXT(MAX_TEXT), .MAX_LINE(MAX_LINE)) u_step (
		.kind(source_bytes.kind), .char_code(source_bytes.char_code),
		.text(word_text_q), .wlen(wlen_q), .digits(digits_q), .fquote(fquote_q),
		.lquote(lquote_q), .line(line_q), .colidx(colidx_q), .cmt(cmt_q),
		.pend(pend_q), .ppos(ppos_q), .lhb(lhb_q),
		.wlen_d(wlen_d), .digits_d(digits_d), .fquote_d(fquote_d), .lquote_d(lquote_d),
		.line_d(line_d), .colidx_d(colidx_d), .cmt_d(cmt_d), .pend_d(pend_d),
		.ppos_d(ppos_d), .lhb_d(lhb_d), .text_we(text_we), .text_idx(text_idx),
		.push(step_push)
	);

	// only an accepted beat pushes results
	always_comb begin
		push = step_push;
		if (!in_fire)
			push.n = 2'd0;
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			digits_q <= 1'b1;
			fquote_q <= 1'b0;
			lquote_q <= 1'b0;
			line_q <= 16'd1;
			colidx_q <= '0;
			cmt_q <= 1'b0;
			pend_q <= PEND_NONE;
			ppos_q <= '0;
			lhb_q <= 1'b0;
		end else if (in_fire) begin
			wlen_q <= wlen_d;
			digits_q <= digits_d;
			fquote_q <= fquote_d;
			lquote_q <= lquote_d;
			line_q <= line_d;
			colidx_q <= colidx_d;
			cmt_q <= cmt_d;
			pend_q <= pend_d;
			ppos_q <= ppos_d;
			lhb_q <= lhb_d;
		end
	end

	// word text store
	always_ff @(posedge clk) begin
		if (in_fire && text_we)
			word_text_q[text_idx] <= source_bytes.char_code;
	end

	stl_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(out_fire),
		.head(head), .count(count)
	);

	assign tokens.valid = (count != 2'd0);
	assign tokens.token_code = head.token_code;
	assign tokens.line_number = head.line_number;
	assign tokens.column = head.column;
	assign tokens.text_length = head.text_length;
	assign tokens.text_first_eight = head.text_first_eight;
	assign tokens.text_next_eight = head.text_next_eight;
	assign tokens.truncated = head.truncated;
	assign tokens.last = head.last;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count != 2'd3)
		else $error("result buffer overflow");
	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && source_bytes.kind |=> line_q == 16'd1 && wlen_q == 17'd0 && !lhb_q)
		else $error("end of input did not reset the lexer");
	a_pend_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != PEND_NONE |-> wlen_q == 17'd0)
		else $error("compare operator held with an open word");
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.token_code == TK_EOF |-> tokens.last)
		else $error("end-of-file token not marked last");

endmodule

@@ tb/sv/source_text_tokenizer_core_tb.sv @@
// source_text_tokenizer_core_tb: self-checking bench for the source text tokenizer core.
// A directed table, then random source text; results are checked against a local lexer model.
// Depends on stl_pkg, stl_in_if, stl_out_if and source_text_tokenizer_core.
module source_text_tokenizer_core_tb;
	import stl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TEXT_CAP = 16;
	localparam int LINE_CAP = 1024;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit   kind;
		byte  ch;
		bit   typed;
		tok_t want;
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	stl_in_if  src_if ();
	stl_out_if tok_if ();

	source_text_tokenizer_core #(.MAX_TEXT(TEXT_CAP), .MAX_LINE(LINE_CAP)) u_top (
		.clk(clk), .arst_n(arst_n), .source_bytes(src_if), .tokens(tok_if));

	always #4 clk = ~clk;

	src_item_t  stim_q[$];
	tok_t       token_q[$];
	int         err_cnt = 0;
	int         tok_seen = 0;
	int         cycles = 0;
	bit         calm = 1'b0;     // no random idling on either side while set
	bit         long_hold = 1'b0; // receiver backs off for a long stretch

	// lexer model state
	logic [7:0]  wbuf [TEXT_CAP+1];
	int unsigned wlen;
	bit          all_dig, q_first, q_last, in_cmt, line_bytes;
	int unsigned cur_line, col_idx, pend_pos;
	int          pend; // PEND_* code
	string kw_list [14] = '{"for", "or", "if", "else", "return", "print", "int", "str",
		"true", "false", "nil", "and", "while", "def"};
	string op_list [22] = '{",", ";", "(", ")", "{", "}", "+", "-", "*", "/", "|", "&", "^",
		":", ">", ">=", "<", "<=", "=", "==", "!", "!="};

	function automatic void lex_clear();
		foreach (wbuf[i]) wbuf[i] = 8'h00;
		wlen = 0; all_dig = 1; q_first = 0; q_last = 0;
		cur_line = 1; col_idx = 0; in_cmt = 0; pend = PEND_NONE; pend_pos = 0;
		line_bytes = 0;
	endfunction

	function automatic int unsigned col_at(int unsigned idx);
		return (idx + 1 > LINE_CAP) ? LINE_CAP : idx + 1;
	endfunction

	function automatic void emit_token(logic [5:0] code, int unsigned col, int unsigned len,
			logic [127:0] txt, bit trunc);
		tok_t t;
		t = '0;
		t.token_code = code;
		t.line_number = cur_line[15:0];
		t.column = col[10:0];
		t.text_length = (len > 65535) ? 16'hffff : len[15:0];
		t.text_first_eight = txt[63:0];
		t.text_next_eight = txt[127:64];
		t.truncated = trunc;
		token_q = {token_q, t};
	endfunction

	function automatic void emit_op(int idx, int unsigned col);
		logic [127:0] txt;
		txt = '0;
		for (int i = 0; i < op_list[idx].len(); i++) txt[8*i +: 8] = op_list[idx][i];
		emit_token(TK_OP0 + 6'(idx), col, op_list[idx].len(), txt, 1'b0);
	endfunction

	// word ends: keyword, integer, quoted string or identifier
	function automatic void close_word(int unsigned col);
		logic [5:0] code;
		int unsigned off, len, n;
		logic [127:0] txt;
		bit hit;
		if (wlen == 0) return;
		code = TK_IDENT; off = 0; len = wlen; hit = 0; txt = '0;
		foreach (kw_list[k]) begin
			if (!hit && kw_list[k].len() == wlen) begin
				hit = 1;
				for (int j = 0; j < kw_list[k].len(); j++)
					if (wbuf[j] != kw_list[k][j]) hit = 0;
				if (hit) code = TK_KW0 + 6'(k);
			end
		end
		if (!hit && all_dig) code = TK_INT;
		else if (!hit && q_first && q_last) begin
			code = TK_STR;
			off = 1;
			len = (wlen >= 2) ? wlen - 2 : 0;
		end
		n = (len > TEXT_CAP) ? TEXT_CAP : len;
		for (int i = 0; i < n; i++) txt[8*i +: 8] = wbuf[off+i];
		emit_token(code, col, len, txt, len > TEXT_CAP);
		wlen = 0; all_dig = 1; q_first = 0; q_last = 0;
	endfunction

	// held compare operator: two-char form when eq, else one-char form
	function automatic void settle_cmp(bit eq);
		int p;
		p = pend;
		pend = PEND_NONE;
		if (p == PEND_NONE) return;
		emit_op(OP_CMP0 + 2 * (p - 1) + eq, eq ? col_at(col_idx) : col_at(pend_pos));
	endfunction

	function automatic bit is_single(byte c);
		for (int i = 0; i < 14; i++) if (op_list[i][0] == c) return 1;
		return 0;
	endfunction

	function automatic bit is_gap(byte c);
		return c inside {8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
	endfunction

	// model one accepted input beat
	function automatic void lex_beat(bit kind, logic [7:0] c);
		int n_prior;
		tok_t t;
		n_prior = token_q.size();
		if (kind) begin
			if (line_bytes) begin
				settle_cmp(0);
				close_word(1);
				if (cur_line < 65535) cur_line++;
			end
			emit_token(TK_EOF, 0, 4, 128'h6c_66_6f_65, 1'b0);
			t = token_q.pop_back();
			t.last = 1'b1;
			token_q = {token_q, t};
			lex_clear();
			return;
		end
		if (c == CH_NL) begin
			settle_cmp(0);
			close_word(1);
			if (cur_line < 65535) cur_line++;
			col_idx = 0; in_cmt = 0; line_bytes = 0;
		end else begin
			line_bytes = 1;
			if (!in_cmt) begin
				if (pend != PEND_NONE && c == CH_EQ) settle_cmp(1);
				else begin
					settle_cmp(0);
					if (c == CH_HASH) begin
						close_word(1);
						in_cmt = 1;
					end else if (c inside {CH_GT, CH_LT, CH_EQ, CH_BANG}) begin
						close_word(col_at(col_idx));
						pend = (c == CH_GT) ? PEND_GT : (c == CH_LT) ? PEND_LT :
							(c == CH_EQ) ? PEND_EQ : PEND_NOT;
						pend_pos = col_idx;
					end else if (is_gap(c)) begin
						close_word(col_at(col_idx));
					end else if (is_single(c)) begin
						close_word(col_at(col_idx));
						for (int i = 0; i < 14; i++)
							if (op_list[i][0] == c) emit_op(i, col_at(col_idx));
					end else begin
						// word byte
						if (wlen < TEXT_CAP + 1) wbuf[wlen] = c;
						if (wlen == 0) q_first = (c == CH_QUOTE);
						q_last = (c == CH_QUOTE);
						if (c < "0" || c > "9") all_dig = 0;
						if (wlen < 65537) wlen++;
					end
				end
			end
			if (col_idx < LINE_CAP) col_idx++;
		end
		if (token_q.size() > n_prior) begin
			t = token_q.pop_back();
			t.last = 1'b1;
			token_q = {token_q, t};
		end
	endfunction

	// stimulus builders
	function automatic void add_byte(byte c);
		src_item_t it;
		it.kind = 0; it.ch = c; it.typed = 0; it.want = '0;
		stim_q = {stim_q, it};
	endfunction

	function automatic void add_eof();
		src_item_t it;
		it.kind = 1; it.ch = byte'($urandom); it.typed = 0; it.want = '0;
		stim_q = {stim_q, it};
	endfunction

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic void add_typed(bit kind, byte c, logic [5:0] code, int unsigned ln,
			int unsigned col, int unsigned len, logic [63:0] txt);
		src_item_t it;
		it.kind = kind; it.ch = c; it.typed = 1; it.want = '0;
		it.want.token_code = code; it.want.line_number = ln[15:0];
		it.want.column = col[10:0];
		it.want.text_length = len[15:0]; it.want.text_first_eight = txt; it.want.last = 1'b1;
		stim_q = {stim_q, it};
	endfunction

	function automatic byte word_byte();
		byte c;
		do c = byte'($urandom);
		while (c == CH_NL || c == CH_HASH || c == CH_QUOTE || is_gap(c) || is_single(c) ||
			c inside {CH_GT, CH_LT, CH_EQ, CH_BANG});
		return c;
	endfunction

	function automatic void add_ident(int n);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 3) == 0) add_byte(word_byte());
			else add_byte(byte'($urandom_range("a", "z")));
	endfunction

	function automatic void add_sep();
		byte seps [5] = '{8'd9, 8'd11, 8'd12, 8'd13, 8'd32};
		add_byte(seps[$urandom_range(0, 4)]);
	endfunction

	// mostly well-formed source text, with noise
	function automatic void add_random_piece();
		int r;
		byte cmps [4] = '{CH_GT, CH_LT, CH_EQ, CH_BANG};
		r = $urandom_range(0, 99);
		if (r < 20) begin
			add_str(kw_list[$urandom_range(0, 13)]);
			if ($urandom_range(0, 2) != 0) add_sep();
		end else if (r < 30) begin
			repeat ($urandom_range(1, 6)) add_byte(byte'($urandom_range("0", "9")));
			add_sep();
		end else if (r < 38) begin
			add_byte(CH_QUOTE);
			add_ident(($urandom_range(0, 5) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 6));
			add_byte(CH_QUOTE);
			add_sep();
		end else if (r < 50) begin
			add_ident(($urandom_range(0, 6) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 7));
		end else if (r < 62) begin
			add_byte(op_list[$urandom_range(0, 13)][0]);
		end else if (r < 72) begin
			add_byte(cmps[$urandom_range(0, 3)]);
			if ($urandom_range(0, 1)) add_byte(CH_EQ);
		end else if (r < 82) begin
			add_sep();
		end else if (r < 88) begin
			add_byte(CH_NL);
		end else if (r < 92) begin
			add_byte(CH_HASH);
			repeat ($urandom_range(0, 5)) add_byte(word_byte());
			add_byte(CH_NL);
		end else if (r < 98) begin
			add_byte(byte'($urandom));
		end else
			add_eof();
	endfunction

	// input defaults and reset
	initial begin
		src_if.valid = 1'b0;
		src_if.kind = 1'b0;
		src_if.char_code = 8'h00;
		tok_if.ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random backpressure, check every beat
	initial begin
		int w;
		tok_t e;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = calm ? 0 : $urandom_range(0, 6);
			if (long_hold) begin
				w = 300;
				long_hold = 0;
			end
			if (w > 0) begin
				tok_if.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			tok_if.ready <= 1'b1;
			do @(posedge clk); while (!tok_if.valid);
			tok_seen++;
			if (token_q.size() == 0) begin
				$error("token beat with nothing expected, code %0d", tok_if.token_code);
				err_cnt++;
			end else begin
				e = token_q.pop_front();
				if (tok_if.token_code !== e.token_code) begin
					$error("token_code exp %0d got %0d", e.token_code, tok_if.token_code);
					err_cnt++;
				end
				if (tok_if.line_number !== e.line_number) begin
					$error("line_number exp %0d got %0d", e.line_number, tok_if.line_number);
					err_cnt++;
				end
				if (tok_if.column !== e.column) begin
					$error("column exp %0d got %0d", e.column, tok_if.column);
					err_cnt++;
				end
				if (tok_if.text_length !== e.text_length) begin
					$error("text_length exp %0d got %0d", e.text_length, tok_if.text_length);
					err_cnt++;
				end
				if (tok_if.text_first_eight !== e.text_first_eight) begin
					$error("text_first_eight exp %h got %h", e.text_first_eight,
						tok_if.text_first_eight);
					err_cnt++;
				end
				if (tok_if.text_next_eight !== e.text_next_eight) begin
					$error("text_next_eight exp %h got %h", e.text_next_eight,
						tok_if.text_next_eight);
					err_cnt++;
				end
				if (tok_if.truncated !== e.truncated) begin
					$error("truncated exp %0d got %0d", e.truncated, tok_if.truncated);
					err_cnt++;
				end
				if (tok_if.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, tok_if.last);
					err_cnt++;
				end
			end
		end
	end

	// source side: build stimulus, drive beats, model each accepted one
	initial begin
		int gap;
		int n_dir, n_rand;
		src_item_t it;
		lex_clear();

		// directed table
		add_typed(1, 8'h00, TK_EOF, 1, 0, 4, 64'h6c_66_6f_65);
		add_typed(0, "(", TK_OP0 + 6'd2, 1, 1, 1, 64'h28);
		add_str("if ");
		add_str(">=!x ");
		add_str("\"\" \" ");
		add_byte(8'h00); add_byte(8'hff); add_str("9 01");
		add_byte(CH_NL);
		add_typed(0, ";", TK_OP0 + 6'd1, 2, 1, 1, 64'h3b);
		add_byte(CH_EQ); add_byte(CH_NL);
		add_str("w#{"); add_byte(CH_NL);
		add_byte(CH_LT); add_eof();
		n_dir = stim_q.size();

		// random source text, with one overlong line and one overlong word
		while (stim_q.size() < n_dir + 1950) begin
			add_random_piece();
			if (stim_q.size() > n_dir + 900 && stim_q.size() < n_dir + 920) begin
				add_byte(CH_NL);
				repeat (1028) add_byte(8'd32);
				add_str("ab,"); add_ident(40); add_byte(CH_GT); add_byte(CH_NL);
			end
		end
		add_eof();
		n_rand = stim_q.size() - n_dir;

		@(posedge arst_n);
		foreach (stim_q[i]) begin
			it = stim_q[i];
			if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i == n_dir + 200) long_hold = 1;
			@(negedge clk);
			gap = (calm || (i >= n_dir + 200 && i < n_dir + 260)) ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				src_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			src_if.valid <= 1'b1;
			src_if.kind <= it.kind;
			src_if.char_code <= it.ch;
			do @(posedge clk); while (!src_if.ready);
			lex_beat(it.kind, it.ch);
			if (it.typed) begin
				void'(token_q.pop_back());
				token_q = {token_q, it.want};
			end
		end
		@(negedge clk);
		src_if.valid <= 1'b0;

		while (token_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d directed and %0d random source beats sent, %0d tokens checked",
			n_dir, n_rand, tok_seen);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
